[rtl/sqd_pkg.sv]
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared constants and types for the segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package sqd_pkg;

    // input field and bus widths
    localparam int FIELD_WIDTH   = 48;
    localparam int S_TDATA_WIDTH = 4 * FIELD_WIDTH;
    localparam int DIST_WIDTH    = 18;
    localparam int M_TDATA_WIDTH = 24;

    // unsigned 1.16 segment parameters
    localparam int FRAC_BITS = 16;
    localparam int Q_WIDTH   = 17;
    localparam logic [Q_WIDTH-1:0] ONE_Q = 17'h10000;
    localparam logic [Q_WIDTH-1:0] Q_SAT = 17'h1ffff;

    // squared residual is in units of 2^-48, distance in 2^-8
    localparam int SQ_SHIFT = 32;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = 18'h3ffff;

    // per-item flags inside the quotient pipeline
    typedef struct packed {
        logic neg;
        logic sat;
        logic zero;
    } div_flag_t;

endpackage

[rtl/sqd_div_pipe.sv]
// ----------------------------------------------------------------------------
// sqd_div_pipe
// Pipelined signed quotient trunc(num * 2^16 / den), clamped to [0, 1.0] in
// unsigned 1.16, one quotient bit per stage, with a payload carried alongside.
// ----------------------------------------------------------------------------
module sqd_div_pipe #(
    parameter int NW = 74,
    parameter int PW = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [NW-1:0]          in_num,
    input  logic signed [NW-1:0]          in_den,
    input  logic [PW-1:0]                 in_pay,
    output logic                          out_valid,
    output logic [sqd_pkg::Q_WIDTH-1:0]   out_q,
    output logic                          out_changed,
    output logic [PW-1:0]                 out_pay
);

    localparam int QW = sqd_pkg::Q_WIDTH;
    localparam int FB = sqd_pkg::FRAC_BITS;

    // magnitude stage
    logic                a_vld_reg;
    logic [NW-1:0]       a_num_reg;
    logic [NW-1:0]       a_den_reg;
    logic                a_neg_reg;
    logic [PW-1:0]       a_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_num_reg <= in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
            a_den_reg <= in_den[NW-1] ? NW'(-in_den) : NW'(in_den);
            a_neg_reg <= in_num[NW-1] ^ in_den[NW-1];
            a_pay_reg <= in_pay;
        end
    end

    // quotient bit stages: index 0 takes the integer bit, then one fraction bit each
    logic                    vld_reg [FB+1];
    logic [NW-1:0]           rem_reg [FB+1];
    logic [NW-1:0]           den_reg [FB+1];
    logic [QW-1:0]           q_reg   [FB+1];
    sqd_pkg::div_flag_t      flg_reg [FB+1];
    logic [PW-1:0]           pay_reg [FB+1];

    genvar s;
    for (s = 0; s <= FB; s++) begin : g_step
        logic               v_next;
        logic [NW-1:0]      rem_next;
        logic [NW-1:0]      den_next;
        logic [QW-1:0]      q_next;
        sqd_pkg::div_flag_t flg_next;
        logic [PW-1:0]      pay_next;

        if (s == 0) begin : g_first
            logic ge;
            // saturation check against twice the divisor and the integer bit
            always_comb begin
                ge            = (a_num_reg >= a_den_reg);
                v_next        = a_vld_reg;
                den_next      = a_den_reg;
                rem_next      = ge ? NW'(a_num_reg - a_den_reg) : a_num_reg;
                q_next        = QW'(ge);
                flg_next.neg  = a_neg_reg;
                flg_next.sat  = ({1'b0, a_num_reg} >= {a_den_reg, 1'b0});
                flg_next.zero = (a_den_reg == '0);
                pay_next      = a_pay_reg;
            end
        end else begin : g_frac
            logic [NW:0] rem2;
            logic        ge;
            // restoring step: shift, compare, subtract
            always_comb begin
                rem2     = {rem_reg[s-1], 1'b0};
                ge       = (rem2 >= {1'b0, den_reg[s-1]});
                v_next   = vld_reg[s-1];
                den_next = den_reg[s-1];
                rem_next = ge ? NW'(rem2 - {1'b0, den_reg[s-1]}) : rem2[NW-1:0];
                q_next   = {q_reg[s-1][QW-2:0], ge};
                flg_next = flg_reg[s-1];
                pay_next = pay_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= v_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_next;
                q_reg[s]   <= q_next;
                flg_reg[s] <= flg_next;
                pay_reg[s] <= pay_next;
            end
        end
    end

    // sign and clamp to [0, 1.0]
    logic              o_vld_reg;
    logic [QW-1:0]     o_q_reg;
    logic              o_ch_reg;
    logic [PW-1:0]     o_pay_reg;
    logic [QW-1:0]     mag;
    logic [QW-1:0]     q_next;
    logic              ch_next;

    always_comb begin
        if (flg_reg[FB].zero) begin
            mag = '0;
        end else if (flg_reg[FB].sat) begin
            mag = sqd_pkg::Q_SAT;
        end else begin
            mag = q_reg[FB];
        end
        if (flg_reg[FB].neg && (mag != '0)) begin
            q_next  = '0;
            ch_next = 1'b1;
        end else if (mag > sqd_pkg::ONE_Q) begin
            q_next  = sqd_pkg::ONE_Q;
            ch_next = 1'b1;
        end else begin
            q_next  = mag;
            ch_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= vld_reg[FB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_q_reg   <= q_next;
            o_ch_reg  <= ch_next;
            o_pay_reg <= pay_reg[FB];
        end
    end

    assign out_valid   = o_vld_reg;
    assign out_q       = o_q_reg;
    assign out_changed = o_ch_reg;
    assign out_pay     = o_pay_reg;

endmodule

[rtl/segment_to_segment_distance_top.sv]
// ----------------------------------------------------------------------------
// segment_to_segment_distance_top
// Shortest distance between two line segments given as signed Q8.8 points,
// answered in unsigned Q8.8 as the floor of the exact square root.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock and returns one distance per pair, in
// order. Seven stages form the differences, the exact dot products and the
// determinant (wide products split into partial products over two stages),
// three 19-stage quotient pipelines in series produce t, u and the reclamped
// t one bit per stage, five stages build the squared residual and the square
// root takes one result bit per stage. The whole pipeline advances together
// and holds while a finished distance is not taken.
module segment_to_segment_distance_top #(
    parameter int DIM         = 3,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_start, first_end, second_start, second_end (48 bits each)
    input  logic [sqd_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // distance [17:0], zero fill above
    output logic [sqd_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int FW   = sqd_pkg::FIELD_WIDTH;
    localparam int QW   = sqd_pkg::Q_WIDTH;
    localparam int FB   = sqd_pkg::FRAC_BITS;
    localparam int PKW  = DIM * CW;
    localparam int EXW  = FW + PKW;
    localparam int DW   = CW + 1;
    localparam int MW   = 2 * DW;
    localparam int SW   = MW + $clog2(DIM);
    localparam int HS   = (SW + 1) / 2;
    localparam int PWW  = 2 * SW;
    localparam int DNW  = 2 * SW + 1;
    localparam int TRW  = SW + QW + 1;
    localparam int AW   = DW + QW + 1;
    localparam int RW   = DW + QW + 2;
    localparam int HR   = (RW + 1) / 2;
    localparam int SQ2  = 2 * RW;
    localparam int SQW  = SQ2 + $clog2(DIM);
    localparam int XW   = SQW - sqd_pkg::SQ_SHIFT;
    localparam int QB   = (XW + 1) / 2;
    localparam int XPW  = 2 * QB;
    localparam int REMW = QB + 4;
    localparam int DCW  = (QB > sqd_pkg::DIST_WIDTH) ? QB : sqd_pkg::DIST_WIDTH;

    typedef struct packed {
        logic [DIM-1:0][DW-1:0]     d1;
        logic [DIM-1:0][DW-1:0]     d2;
        logic [DIM-1:0][DW-1:0]     d12;
        logic signed [SW-1:0]       dd1;
        logic signed [SW-1:0]       dd2;
        logic signed [SW-1:0]       ss1;
        logic signed [SW-1:0]       ss2;
        logic signed [SW-1:0]       rr;
        logic                       d1z;
        logic                       d2z;
        logic                       nondeg;
        logic                       gen;
        logic                       tuse;
        logic [QW-1:0]              tk;
        logic [QW-1:0]              uq;
        logic                       uch;
    } ctx_t;

    localparam int CTXW = $bits(ctx_t);

    // whole pipeline advances when the output register is free or drained
    logic adv;
    logic m_tvalid_reg;
    logic [sqd_pkg::DIST_WIDTH-1:0] dist_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: unpack coordinates and form direction vectors
    logic [EXW-1:0]       fs_ext, fe_ext, ss_ext, se_ext;
    logic signed [DW-1:0] ca [DIM];
    logic signed [DW-1:0] cb [DIM];
    logic signed [DW-1:0] cc [DIM];
    logic signed [DW-1:0] ce [DIM];
    ctx_t ctx1_next, ctx1_reg;
    logic v1_reg;

    always_comb begin
        fs_ext    = {{PKW{1'b0}}, s_tdata[FW-1:0]};
        fe_ext    = {{PKW{1'b0}}, s_tdata[2*FW-1:FW]};
        ss_ext    = {{PKW{1'b0}}, s_tdata[3*FW-1:2*FW]};
        se_ext    = {{PKW{1'b0}}, s_tdata[4*FW-1:3*FW]};
        ctx1_next = '0;
        for (int k = 0; k < DIM; k++) begin
            ca[k] = DW'($signed(fs_ext[k*CW +: CW]));
            cb[k] = DW'($signed(fe_ext[k*CW +: CW]));
            cc[k] = DW'($signed(ss_ext[k*CW +: CW]));
            ce[k] = DW'($signed(se_ext[k*CW +: CW]));
            ctx1_next.d1[k]  = cb[k] - ca[k];
            ctx1_next.d2[k]  = ce[k] - cc[k];
            ctx1_next.d12[k] = cc[k] - ca[k];
        end
    end

    // stage 2: per-axis products
    logic signed [MW-1:0] p11_reg [DIM];
    logic signed [MW-1:0] p22_reg [DIM];
    logic signed [MW-1:0] p1c_reg [DIM];
    logic signed [MW-1:0] p2c_reg [DIM];
    logic signed [MW-1:0] p12_reg [DIM];
    ctx_t ctx2_reg;
    logic v2_reg;

    // stage 3: dot product sums
    ctx_t ctx3_next, ctx3_reg;
    logic v3_reg;

    always_comb begin
        ctx3_next     = ctx2_reg;
        ctx3_next.dd1 = '0;
        ctx3_next.dd2 = '0;
        ctx3_next.ss1 = '0;
        ctx3_next.ss2 = '0;
        ctx3_next.rr  = '0;
        for (int k = 0; k < DIM; k++) begin
            ctx3_next.dd1 = ctx3_next.dd1 + SW'(p11_reg[k]);
            ctx3_next.dd2 = ctx3_next.dd2 + SW'(p22_reg[k]);
            ctx3_next.ss1 = ctx3_next.ss1 + SW'(p1c_reg[k]);
            ctx3_next.ss2 = ctx3_next.ss2 + SW'(p2c_reg[k]);
            ctx3_next.rr  = ctx3_next.rr + SW'(p12_reg[k]);
        end
    end

    // stages 4-5: D1*D2, R*R, S1*D2, S2*R as split partial products
    logic signed [SW-1:0] op_a [4];
    logic signed [SW-1:0] op_b [4];
    logic signed [PWW-1:0] wp_reg [4];
    ctx_t ctx4_reg, ctx5_reg;
    logic v4_reg, v5_reg;

    always_comb begin
        op_a[0] = ctx3_reg.dd1;
        op_b[0] = ctx3_reg.dd2;
        op_a[1] = ctx3_reg.rr;
        op_b[1] = ctx3_reg.rr;
        op_a[2] = ctx3_reg.ss1;
        op_b[2] = ctx3_reg.dd2;
        op_a[3] = ctx3_reg.ss2;
        op_b[3] = ctx3_reg.rr;
    end

    genvar j;
    for (j = 0; j < 4; j++) begin : g_wmul
        logic signed [2*(SW-HS)-1:0] hh_reg;
        logic signed [SW:0]          hl_reg;
        logic signed [SW:0]          lh_reg;
        logic [2*HS-1:0]             ll_reg;

        always_ff @(posedge aclk) begin
            if (adv) begin
                hh_reg <= $signed(op_a[j][SW-1:HS]) * $signed(op_b[j][SW-1:HS]);
                hl_reg <= $signed(op_a[j][SW-1:HS]) * $signed({1'b0, op_b[j][HS-1:0]});
                lh_reg <= $signed({1'b0, op_a[j][HS-1:0]}) * $signed(op_b[j][SW-1:HS]);
                ll_reg <= op_a[j][HS-1:0] * op_b[j][HS-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                wp_reg[j] <= (PWW'(hh_reg) <<< (2 * HS))
                           + ((PWW'(hl_reg) + PWW'(lh_reg)) <<< HS)
                           + $signed(PWW'(ll_reg));
            end
        end
    end

    // stage 6: determinant and general-case numerator
    logic signed [DNW-1:0] den6_reg, num6_reg;
    ctx_t ctx6_next, ctx6_reg;
    logic v6_reg;

    always_comb begin
        ctx6_next        = ctx5_reg;
        ctx6_next.d1z    = (ctx5_reg.dd1 == '0);
        ctx6_next.d2z    = (ctx5_reg.dd2 == '0);
        ctx6_next.nondeg = (ctx5_reg.dd1 != '0) && (ctx5_reg.dd2 != '0);
    end

    // stage 7: case selection and first quotient operands
    logic signed [DNW-1:0] n7_reg, dv7_reg;
    ctx_t ctx7_next, ctx7_reg;
    logic v7_reg;
    logic den6_nz;

    always_comb begin
        den6_nz        = (den6_reg != '0);
        ctx7_next      = ctx6_reg;
        ctx7_next.gen  = ctx6_reg.nondeg && den6_nz;
        ctx7_next.tuse = !ctx6_reg.d1z && (ctx6_reg.d2z || den6_nz);
    end

    // first quotient: t in the general case, S1/D1 when only the second is a point
    logic              v8;
    logic [QW-1:0]     t8;
    logic [CTXW-1:0]   pay8;
    ctx_t              ctx8;

    sqd_div_pipe #(.NW(DNW), .PW(CTXW)) u_div_t (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (v7_reg),
        .in_num     (n7_reg),
        .in_den     (dv7_reg),
        .in_pay     (ctx7_reg),
        .out_valid  (v8),
        .out_q      (t8),
        .out_changed(),
        .out_pay    (pay8)
    );

    assign ctx8 = pay8;

    // stage 9: t*R for the u quotient
    logic [QW-1:0]         tsel9;
    logic signed [TRW-1:0] tr9_reg;
    ctx_t ctx9_next, ctx9_reg;
    logic v9_reg;

    always_comb begin
        tsel9        = ctx8.gen ? t8 : '0;
        ctx9_next    = ctx8;
        ctx9_next.tk = ctx8.tuse ? t8 : '0;
    end

    // stage 10: u quotient operands
    logic signed [DNW-1:0] nu10_reg, du10_reg;
    ctx_t ctx10_reg;
    logic v10_reg;

    // second quotient: u, clamped
    logic              v11;
    logic [QW-1:0]     u11;
    logic              uch11;
    logic [CTXW-1:0]   pay11;
    ctx_t              ctx11;

    sqd_div_pipe #(.NW(DNW), .PW(CTXW)) u_div_u (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (v10_reg),
        .in_num     (nu10_reg),
        .in_den     (du10_reg),
        .in_pay     (ctx10_reg),
        .out_valid  (v11),
        .out_q      (u11),
        .out_changed(uch11),
        .out_pay    (pay11)
    );

    assign ctx11 = pay11;

    // stage 12: u*R for the reclamped t
    logic signed [TRW-1:0] ur12_reg;
    ctx_t ctx12_next, ctx12_reg;
    logic v12_reg;

    always_comb begin
        ctx12_next     = ctx11;
        ctx12_next.uq  = u11;
        ctx12_next.uch = uch11;
    end

    // stage 13: reclamp quotient operands
    logic signed [DNW-1:0] nt13_reg, dt13_reg;
    ctx_t ctx13_reg;
    logic v13_reg;

    // third quotient: t recomputed from the clamped u
    logic              v14;
    logic [QW-1:0]     t14;
    logic [CTXW-1:0]   pay14;
    ctx_t              ctx14;

    sqd_div_pipe #(.NW(DNW), .PW(CTXW)) u_div_r (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (v13_reg),
        .in_num     (nt13_reg),
        .in_den     (dt13_reg),
        .in_pay     (ctx13_reg),
        .out_valid  (v14),
        .out_q      (t14),
        .out_changed(),
        .out_pay    (pay14)
    );

    assign ctx14 = pay14;

    // stage 15: final t and per-axis scaled directions
    logic [QW-1:0]          tf15;
    logic [QW-1:0]          t15_reg, u15_reg;
    logic signed [AW-1:0]   pa15_reg [DIM];
    logic signed [AW-1:0]   pb15_reg [DIM];
    logic [DIM-1:0][DW-1:0] d12_15_reg;
    logic v15_reg;

    assign tf15 = (ctx14.nondeg && ctx14.uch) ? t14 : ctx14.tk;

    // stage 16: residual per axis
    logic signed [RW-1:0] r16_reg [DIM];
    logic v16_reg;

    // stages 17-18: squared residual per axis
    logic signed [SQ2-1:0] sq18_reg [DIM];
    logic v17_reg, v18_reg;

    genvar k;
    for (k = 0; k < DIM; k++) begin : g_sq
        logic signed [2*(RW-HR)-1:0] hh_reg;
        logic signed [RW:0]          hl_reg;
        logic [2*HR-1:0]             ll_reg;

        always_ff @(posedge aclk) begin
            if (adv) begin
                hh_reg <= $signed(r16_reg[k][RW-1:HR]) * $signed(r16_reg[k][RW-1:HR]);
                hl_reg <= $signed(r16_reg[k][RW-1:HR])
                        * $signed({1'b0, r16_reg[k][HR-1:0]});
                ll_reg <= r16_reg[k][HR-1:0] * r16_reg[k][HR-1:0];
            end
        end

        // cross term appears twice
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq18_reg[k] <= (SQ2'(hh_reg) <<< (2 * HR))
                             + (SQ2'(hl_reg) <<< (HR + 1))
                             + $signed(SQ2'(ll_reg));
            end
        end
    end

    // stage 19: sum of squares
    logic [SQW-1:0] sum19_next, sum19_reg;
    logic v19_reg;

    always_comb begin
        sum19_next = '0;
        for (int a = 0; a < DIM; a++) begin
            sum19_next = sum19_next + SQW'(sq18_reg[a]);
        end
    end

    // main pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            v15_reg <= 1'b0;
            v16_reg <= 1'b0;
            v17_reg <= 1'b0;
            v18_reg <= 1'b0;
            v19_reg <= 1'b0;
        end else if (adv) begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v9_reg  <= v8;
            v10_reg <= v9_reg;
            v12_reg <= v11;
            v13_reg <= v12_reg;
            v15_reg <= v14;
            v16_reg <= v15_reg;
            v17_reg <= v16_reg;
            v18_reg <= v17_reg;
            v19_reg <= v18_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx1_reg <= ctx1_next;

            ctx2_reg <= ctx1_reg;
            for (int a = 0; a < DIM; a++) begin
                p11_reg[a] <= $signed(ctx1_reg.d1[a]) * $signed(ctx1_reg.d1[a]);
                p22_reg[a] <= $signed(ctx1_reg.d2[a]) * $signed(ctx1_reg.d2[a]);
                p1c_reg[a] <= $signed(ctx1_reg.d1[a]) * $signed(ctx1_reg.d12[a]);
                p2c_reg[a] <= $signed(ctx1_reg.d2[a]) * $signed(ctx1_reg.d12[a]);
                p12_reg[a] <= $signed(ctx1_reg.d1[a]) * $signed(ctx1_reg.d2[a]);
            end

            ctx3_reg <= ctx3_next;
            ctx4_reg <= ctx3_reg;
            ctx5_reg <= ctx4_reg;

            ctx6_reg <= ctx6_next;
            den6_reg <= DNW'(wp_reg[0]) - DNW'(wp_reg[1]);
            num6_reg <= DNW'(wp_reg[2]) - DNW'(wp_reg[3]);

            ctx7_reg <= ctx7_next;
            n7_reg   <= ctx7_next.gen ? num6_reg : DNW'($signed(ctx6_reg.ss1));
            dv7_reg  <= ctx7_next.gen ? den6_reg : DNW'($signed(ctx6_reg.dd1));

            ctx9_reg <= ctx9_next;
            tr9_reg  <= $signed({1'b0, tsel9}) * $signed(ctx8.rr);

            ctx10_reg <= ctx9_reg;
            nu10_reg  <= DNW'(tr9_reg) - (DNW'($signed(ctx9_reg.ss2)) <<< FB);
            du10_reg  <= DNW'($signed(ctx9_reg.dd2)) <<< FB;

            ctx12_reg <= ctx12_next;
            ur12_reg  <= $signed({1'b0, u11}) * $signed(ctx11.rr);

            ctx13_reg <= ctx12_reg;
            nt13_reg  <= DNW'(ur12_reg) + (DNW'($signed(ctx12_reg.ss1)) <<< FB);
            dt13_reg  <= DNW'($signed(ctx12_reg.dd1)) <<< FB;

            t15_reg    <= tf15;
            u15_reg    <= ctx14.uq;
            d12_15_reg <= ctx14.d12;
            for (int a = 0; a < DIM; a++) begin
                pa15_reg[a] <= $signed(ctx14.d1[a]) * $signed({1'b0, tf15});
                pb15_reg[a] <= $signed(ctx14.d2[a]) * $signed({1'b0, ctx14.uq});
            end

            for (int a = 0; a < DIM; a++) begin
                r16_reg[a] <= RW'(pa15_reg[a]) - RW'(pb15_reg[a])
                            - (RW'($signed(d12_15_reg[a])) <<< FB);
            end

            sum19_reg <= sum19_next;
        end
    end

    // square root, one result bit per stage
    logic              iv_reg    [QB];
    logic [REMW-1:0]   irem_reg  [QB];
    logic [QB-1:0]     iroot_reg [QB];
    logic [XPW-1:0]    ix_reg    [QB];

    genvar i;
    for (i = 0; i < QB; i++) begin : g_sqrt
        logic            v_in;
        logic [REMW-1:0] rem_in;
        logic [QB-1:0]   root_in;
        logic [XPW-1:0]  x_in;
        logic [REMW-1:0] rem2;
        logic [REMW-1:0] trial;
        logic            ge;

        if (i == 0) begin : g_head
            assign v_in    = v19_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = XPW'(sum19_reg[SQW-1:sqd_pkg::SQ_SHIFT]);
        end else begin : g_body
            assign v_in    = iv_reg[i-1];
            assign rem_in  = irem_reg[i-1];
            assign root_in = iroot_reg[i-1];
            assign x_in    = ix_reg[i-1];
        end

        // bring down two bits, try root*4+1
        always_comb begin
            rem2  = {rem_in[REMW-3:0], x_in[XPW-1 -: 2]};
            trial = REMW'({root_in, 2'b01});
            ge    = (rem2 >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                iv_reg[i] <= 1'b0;
            end else if (adv) begin
                iv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                irem_reg[i]  <= ge ? REMW'(rem2 - trial) : rem2;
                iroot_reg[i] <= {root_in[QB-2:0], ge};
                ix_reg[i]    <= {x_in[XPW-3:0], 2'b00};
            end
        end
    end

    // saturate and register the result
    logic [DCW-1:0]                 root_w;
    logic [sqd_pkg::DIST_WIDTH-1:0] dist_next;

    always_comb begin
        root_w = DCW'(iroot_reg[QB-1]);
        if (root_w > DCW'(sqd_pkg::DIST_MAX)) begin
            dist_next = sqd_pkg::DIST_MAX;
        end else begin
            dist_next = root_w[sqd_pkg::DIST_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= iv_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg <= dist_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(sqd_pkg::M_TDATA_WIDTH - sqd_pkg::DIST_WIDTH){1'b0}}, dist_reg};

    // squared lengths are never negative
    a_len_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> !ctx3_reg.dd1[SW-1] && !ctx3_reg.dd2[SW-1])
        else $error("squared direction length negative");

    // determinant D1*D2 - R*R is never negative
    a_den_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        v6_reg |-> !den6_reg[DNW-1])
        else $error("determinant negative");

    // final segment parameters lie in [0, 1.0]
    a_param_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v15_reg |-> (t15_reg <= sqd_pkg::ONE_Q) && (u15_reg <= sqd_pkg::ONE_Q))
        else $error("segment parameter out of range");

endmodule

[sim/tb_segment_to_segment_distance_top.sv]
// ----------------------------------------------------------------------------
// tb_segment_to_segment_distance_top
// Self-checking bench for the segment-to-segment distance pipeline: a local
// predictor computes the expected distance for every accepted segment pair,
// results are compared in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_segment_to_segment_distance_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIMS  = 3;
    localparam int CW    = 16;
    localparam int LATENCY = 95;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [127:0] ONE_Q16 = 128'sd65536;
    localparam logic [17:0] DIST_SAT = 18'h3ffff;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sqd_pkg::S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sqd_pkg::M_TDATA_WIDTH-1:0] m_tdata;

    logic [17:0] dist_expected_q[$];
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int fail_count = 0;
    int pairs_sent = 0;
    int dists_checked = 0;
    int idle_cycles = 0;

    segment_to_segment_distance_top #(.DIM(DIMS), .COORD_WIDTH(CW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // signed coordinate k of a packed point
    function automatic logic signed [127:0] coord_of(logic [47:0] pt, int k);
        logic signed [15:0] c;
        c = pt[k*CW +: CW];
        return 128'(c);
    endfunction

    // truncated num*2^16/den, magnitude saturated below 2.0
    function automatic logic signed [127:0] quot_q16(logic signed [127:0] num,
                                                     logic signed [127:0] den);
        logic [127:0] an, ad;
        logic signed [127:0] q;
        if (den == 0) return 0;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (an >= (ad << 1)) q = 131071;
        else q = ((an << 16) / ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [127:0] clamp_unit(logic signed [127:0] q,
                                                       output logic hit);
        hit = 1'b1;
        if (q < 0) return 0;
        if (q > ONE_Q16) return ONE_Q16;
        hit = 1'b0;
        return q;
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] x);
        logic [127:0] r, b;
        r = 0;
        for (int i = 40; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= x) r = b;
        end
        return r;
    endfunction

    // closest distance between the two segments, unsigned Q8.8
    function automatic logic [17:0] pair_distance(logic [191:0] pair);
        logic signed [127:0] d1[DIMS], d2[DIMS], d12[DIMS];
        logic signed [127:0] dd1, dd2, s1, s2, rr, den, t, u, res;
        logic [127:0] sum, root;
        logic hit;
        dd1 = 0; dd2 = 0; s1 = 0; s2 = 0; rr = 0; t = 0; u = 0; sum = 0; hit = 0;
        for (int k = 0; k < DIMS; k++) begin
            d1[k]  = coord_of(pair[48 +: 48], k) - coord_of(pair[0 +: 48], k);
            d2[k]  = coord_of(pair[144 +: 48], k) - coord_of(pair[96 +: 48], k);
            d12[k] = coord_of(pair[96 +: 48], k) - coord_of(pair[0 +: 48], k);
            dd1 += d1[k] * d1[k];
            dd2 += d2[k] * d2[k];
            s1  += d1[k] * d12[k];
            s2  += d2[k] * d12[k];
            rr  += d1[k] * d2[k];
        end
        den = dd1 * dd2 - rr * rr;
        if (dd1 == 0 || dd2 == 0) begin
            if (dd1 != 0) t = clamp_unit(quot_q16(s1, dd1), hit);
            else if (dd2 != 0) u = clamp_unit(quot_q16(-s2, dd2), hit);
        end else begin
            if (den == 0) begin
                t = 0;
                u = clamp_unit(quot_q16(-s2, dd2), hit);
            end else begin
                t = clamp_unit(quot_q16(s1 * dd2 - s2 * rr, den), hit);
                u = clamp_unit(quot_q16(t * rr - s2 * ONE_Q16, dd2 * ONE_Q16), hit);
            end
            if (hit) t = clamp_unit(quot_q16(u * rr + s1 * ONE_Q16, dd1 * ONE_Q16), hit);
        end
        for (int k = 0; k < DIMS; k++) begin
            res = d1[k] * t - d2[k] * u - d12[k] * ONE_Q16;
            sum += res * res;
        end
        root = isqrt(sum >> 32);
        return root > DIST_SAT ? DIST_SAT : root[17:0];
    endfunction

    // send one segment pair, honoring the source idle rate
    task automatic send_pair(logic [47:0] s1p, logic [47:0] e1p,
                             logic [47:0] s2p, logic [47:0] e2p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {e2p, s2p, e1p, s1p};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        dist_expected_q.push_back(pair_distance({e2p, s2p, e1p, s1p}));
        pairs_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [47:0] pack_point(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed(8'($urandom)));
            2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
            default: return 16'($signed(12'($urandom)));
        endcase
    endfunction

    function automatic logic [47:0] rand_point();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    // sink stall and result checking
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (dist_expected_q.size() == 0) begin
                $error("distance: unexpected transfer, actual %0d", m_tdata[17:0]);
                fail_count++;
            end else begin
                logic [17:0] want;
                want = dist_expected_q.pop_front();
                if (m_tdata[17:0] !== want) begin
                    $error("distance: expected %0d actual %0d", want, m_tdata[17:0]);
                    fail_count++;
                end
                if (m_tdata[23:18] !== '0) begin
                    $error("pad: expected 0 actual %0h", m_tdata[23:18]);
                    fail_count++;
                end
                dists_checked++;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn && (s_tvalid || dist_expected_q.size() != 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("segment_to_segment_distance_top: mismatch");
                $finish;
            end
        end
    end

    // extremes, points, parallel, crossing, clamped ends
    task automatic test_directed();
        send_pair('0, '0, '0, '0);
        send_pair(pack_point(0, 0, 0), pack_point(0, 0, 0),
                  pack_point(256, 0, 0), pack_point(256, 0, 0));
        send_pair(pack_point(0, 0, 0), pack_point(0, 0, 0),
                  pack_point(-256, 256, 0), pack_point(256, 256, 0));
        send_pair(pack_point(-256, 256, 0), pack_point(256, 256, 0),
                  pack_point(0, 0, 0), pack_point(0, 0, 0));
        send_pair(pack_point(0, 0, 0), pack_point(512, 0, 0),
                  pack_point(0, 256, 0), pack_point(512, 256, 0));
        send_pair(pack_point(0, 0, 0), pack_point(512, 0, 0),
                  pack_point(1024, 256, 0), pack_point(2048, 256, 0));
        send_pair(pack_point(-512, 0, 0), pack_point(512, 0, 0),
                  pack_point(0, -512, 256), pack_point(0, 512, 256));
        send_pair(pack_point(0, 0, 0), pack_point(256, 0, 0),
                  pack_point(1024, -512, 300), pack_point(1024, 512, 300));
        send_pair(pack_point(-32768, -32768, -32768), pack_point(32767, 32767, 32767),
                  pack_point(32767, -32768, 32767), pack_point(-32768, 32767, -32768));
        send_pair(pack_point(-32768, -32768, -32768), pack_point(-32768, -32768, -32768),
                  pack_point(32767, 32767, 32767), pack_point(32767, 32767, 32767));
        send_pair({48{1'b1}}, 48'h7fff_7fff_7fff, 48'h8000_8000_8000, {48{1'b1}});
        send_pair(pack_point(1, 0, 0), pack_point(2, 0, 0),
                  pack_point(0, 1, 0), pack_point(0, 2, 0));
        send_pair(pack_point(0, 0, 0), pack_point(256, 256, 256),
                  pack_point(0, 0, 0), pack_point(256, 256, 256));
    endtask

    // random pairs, including degenerate and parallel shapes
    task automatic test_random(int n);
        logic [47:0] a, b, c, e;
        for (int i = 0; i < n; i++) begin
            a = rand_point(); b = rand_point(); c = rand_point(); e = rand_point();
            case ($urandom_range(7))
                0: b = a;
                1: e = c;
                2: e = c + (b - a);
                default: ;
            endcase
            send_pair(a, b, c, e);
        end
    endtask

    // release the source, then wait for every result and a quiet tail
    task automatic drain();
        s_tvalid <= 1'b0;
        while (dist_expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(100);
        src_idle_pct = 71;
        test_random(110);
        src_idle_pct = 0; snk_stall_pct = 71;
        test_random(110);
        src_idle_pct = 7; snk_stall_pct = 7;
        test_random(110);
        drain();
        $display("covered %0d segment pairs, %0d distances checked,", pairs_sent,
                 dists_checked);
        $display("with idle and stall phases on both sides");
        if (fail_count == 0) $display("segment_to_segment_distance_top: match");
        else $display("segment_to_segment_distance_top: mismatch");
        $finish;
    end
endmodule
